// File: sv/dfpl_pkg.sv
// Shared constants for the dragonfly path length calculator.
package dfpl_pkg;

	// Configuration register indexes
	localparam logic [7:0] REG_NODES_PER_ROUTER   = 8'd0;
	localparam logic [7:0] REG_ROUTERS_PER_GROUP  = 8'd1;
	localparam logic [7:0] REG_GLOBAL_PORTS       = 8'd2;
	localparam logic [7:0] REG_OWN_NODE           = 8'd3;

	// Register field widths
	localparam int P_BITS   = 7;
	localparam int A_BITS   = 8;
	localparam int H_BITS   = 7;
	localparam int OWN_BITS = 16;
	localparam int CFG_DATA_BITS = 16;

	// Router index times port count
	localparam int PROD_BITS = A_BITS + H_BITS;

	// Reset values
	localparam logic [P_BITS-1:0]   P_RESET   = 7'd4;
	localparam logic [A_BITS-1:0]   A_RESET   = 8'd8;
	localparam logic [H_BITS-1:0]   H_RESET   = 7'd4;
	localparam logic [OWN_BITS-1:0] OWN_RESET = 16'd0;

endpackage

// File: sv/dfpl_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module dfpl_div
	import dfpl_pkg::*;
#(
	parameter int W  = 16,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	output logic [W-1:0]  quot,
	output logic [DW-1:0] rem
);

	logic [DW-1:0] rem_s [W];
	logic [W-1:0]  x_s   [W];

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [W-1:0]  x_in;
		logic [DW:0]   trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign x_in   = dividend;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign x_in   = x_s[i-1];
		end

		// Shift in the next dividend bit and try the subtract
		always_comb begin
			trial = {rem_in, x_in[W-1]};
			ge    = trial >= {1'b0, divisor};
		end

		// Advance the partial remainder and quotient
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
				x_s[i]   <= {x_in[W-2:0], ge};
			end
		end
	end

	assign quot = x_s[W-1];
	assign rem  = rem_s[W-1];

endmodule

// File: sv/dfpl_hops.sv
// Palmtree link checks and hop counting, two register stages.
module dfpl_hops
	import dfpl_pkg::*;
#(
	parameter int NB = 16
) (
	input  logic              clk,
	input  logic              en,
	input  logic [H_BITS-1:0] h,
	input  logic [A_BITS-1:0] a_eff,
	input  logic [NB-1:0]     src_grp,
	input  logic [A_BITS-1:0] src_rtr,
	input  logic [NB-1:0]     via_grp,
	input  logic [A_BITS-1:0] via_rtr,
	input  logic [NB-1:0]     dst_grp,
	input  logic [A_BITS-1:0] dst_rtr,
	output logic [1:0]        min_hops,
	output logic [2:0]        detour_hops,
	output logic              bad_node
);

	localparam int CW = ((NB > PROD_BITS) ? NB : PROD_BITS) + 2;

	logic [PROD_BITS-1:0] src_rh_s1, via_rh_s1, dst_rh_s1, lim_s1;
	logic [NB-1:0]        src_grp_s1, via_grp_s1, dst_grp_s1;
	logic [A_BITS-1:0]    src_rtr_s1, via_rtr_s1, dst_rtr_s1;
	logic [H_BITS-1:0]    h_s1;

	// Register the router-by-port products
	always_ff @(posedge clk) begin
		if (en) begin
			src_rh_s1  <= PROD_BITS'(src_rtr * h);
			via_rh_s1  <= PROD_BITS'(via_rtr * h);
			dst_rh_s1  <= PROD_BITS'(dst_rtr * h);
			lim_s1     <= PROD_BITS'(a_eff * h);
			h_s1       <= h;
			src_grp_s1 <= src_grp;
			via_grp_s1 <= via_grp;
			dst_grp_s1 <= dst_grp;
			src_rtr_s1 <= src_rtr;
			via_rtr_s1 <= via_rtr;
			dst_rtr_s1 <= dst_rtr;
		end
	end

	// True when the router at rh of group g owns the link towards group t
	function automatic logic link_here(input logic [NB-1:0] g, input logic [PROD_BITS-1:0] rh,
			input logic [NB-1:0] t, input logic [H_BITS-1:0] hv);
		logic [CW-1:0] lo;
		logic [CW-1:0] tw;
		lo = CW'(rh) + CW'(t > g);
		tw = CW'(t);
		return (tw >= lo) && (tw < lo + CW'(hv));
	endfunction

	logic       l_sd, l_ds, l_sv, l_vd, l_dv;
	logic       same_sd, same_sv, same_vd;
	logic [1:0] min_c, sv_c;
	logic [2:0] vd_c;
	logic       bad_c;

	// Count hops of the minimal and the detour path
	always_comb begin
		l_sd = link_here(src_grp_s1, src_rh_s1, dst_grp_s1, h_s1);
		l_ds = link_here(dst_grp_s1, dst_rh_s1, src_grp_s1, h_s1);
		l_sv = link_here(src_grp_s1, src_rh_s1, via_grp_s1, h_s1);
		l_vd = link_here(via_grp_s1, via_rh_s1, dst_grp_s1, h_s1);
		l_dv = link_here(dst_grp_s1, dst_rh_s1, via_grp_s1, h_s1);
		same_sd = src_grp_s1 == dst_grp_s1;
		same_sv = src_grp_s1 == via_grp_s1;
		same_vd = via_grp_s1 == dst_grp_s1;
		if (same_sd) begin
			min_c = {1'b0, src_rtr_s1 != dst_rtr_s1};
		end else begin
			min_c = 2'd1 + {1'b0, !l_sd} + {1'b0, !l_ds};
		end
		if (same_sv) begin
			sv_c = {1'b0, src_rtr_s1 != via_rtr_s1};
		end else begin
			sv_c = 2'd1 + {1'b0, !l_sv};
		end
		if (same_vd) begin
			vd_c = {2'b0, via_rtr_s1 != dst_rtr_s1};
		end else begin
			vd_c = 3'd1 + {2'b0, !l_vd} + {2'b0, !l_dv};
		end
		bad_c = (CW'(src_grp_s1) > CW'(lim_s1)) || (CW'(via_grp_s1) > CW'(lim_s1))
			|| (CW'(dst_grp_s1) > CW'(lim_s1));
	end

	// Hold the result
	always_ff @(posedge clk) begin
		if (en) begin
			min_hops    <= min_c;
			detour_hops <= {1'b0, sv_c} + vd_c;
			bad_node    <= bad_c;
		end
	end

endmodule

// File: sv/dragonfly_path_length_calc.sv
// Throughput: one request per cycle; the whole pipeline stalls while a result waits.
// Depth is set by the two chained bit-serial dividers (by p, then by a) and the hop stages.
// Reset clears the valid bits and loads the register defaults p=4 a=8 h=4 own=0.
// Configuration writes are always taken; write only while the pipeline is empty.
module dragonfly_path_length_calc
	import dfpl_pkg::*;
#(
	parameter int NODE_ID_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [7:0]               cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [NODE_ID_BITS-1:0]  via_node,
	input  logic [NODE_ID_BITS-1:0]  target_node,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               min_hops,
	output logic [2:0]               detour_hops,
	output logic                     bad_node
);

	localparam int NB  = NODE_ID_BITS;
	localparam int LAT = 2 * NB + 2;

	logic [P_BITS-1:0]   p_q;
	logic [A_BITS-1:0]   a_q;
	logic [H_BITS-1:0]   h_q;
	logic [OWN_BITS-1:0] own_q;

	assign cfg_ready = 1'b1;

	// Write configuration registers, drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q   <= P_RESET;
			a_q   <= A_RESET;
			h_q   <= H_RESET;
			own_q <= OWN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NODES_PER_ROUTER:  p_q   <= cfg_data[P_BITS-1:0];
				REG_ROUTERS_PER_GROUP: a_q   <= cfg_data[A_BITS-1:0];
				REG_GLOBAL_PORTS:      h_q   <= cfg_data[H_BITS-1:0];
				REG_OWN_NODE:          own_q <= cfg_data[OWN_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic [A_BITS-1:0] p_eff, a_eff;
	logic [NB-1:0]     own_id;
	logic              en;
	logic [LAT-1:0]    vld_q;

	// Treat a zero count as one
	assign p_eff  = (p_q == '0) ? A_BITS'(1) : A_BITS'(p_q);
	assign a_eff  = (a_q == '0) ? A_BITS'(1) : a_q;
	assign own_id = NB'(own_q);

	// Advance everything unless a result is stuck at the output
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	logic [NB-1:0]     src_q1, via_q1, dst_q1;
	logic [NB-1:0]     src_grp, via_grp, dst_grp;
	logic [A_BITS-1:0] src_rtr, via_rtr, dst_rtr;

	// Divide each id by p
	dfpl_div #(.W(NB), .DW(A_BITS)) u_src_p (.clk, .en, .dividend(own_id),
		.divisor(p_eff), .quot(src_q1), .rem());
	dfpl_div #(.W(NB), .DW(A_BITS)) u_via_p (.clk, .en, .dividend(via_node),
		.divisor(p_eff), .quot(via_q1), .rem());
	dfpl_div #(.W(NB), .DW(A_BITS)) u_dst_p (.clk, .en, .dividend(target_node),
		.divisor(p_eff), .quot(dst_q1), .rem());

	// Split into group and router by dividing by a
	dfpl_div #(.W(NB), .DW(A_BITS)) u_src_a (.clk, .en, .dividend(src_q1),
		.divisor(a_eff), .quot(src_grp), .rem(src_rtr));
	dfpl_div #(.W(NB), .DW(A_BITS)) u_via_a (.clk, .en, .dividend(via_q1),
		.divisor(a_eff), .quot(via_grp), .rem(via_rtr));
	dfpl_div #(.W(NB), .DW(A_BITS)) u_dst_a (.clk, .en, .dividend(dst_q1),
		.divisor(a_eff), .quot(dst_grp), .rem(dst_rtr));

	// Count hops
	dfpl_hops #(.NB(NB)) u_hops (
		.clk, .en,
		.h(h_q), .a_eff,
		.src_grp, .src_rtr, .via_grp, .via_rtr, .dst_grp, .dst_rtr,
		.min_hops, .detour_hops, .bad_node
	);

endmodule

// File: bench/dragonfly_path_length_calc_tb.sv
// Self-checking testbench for the dragonfly path length calculator.
module dragonfly_path_length_calc_tb
	import dfpl_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ID_BITS = 16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 2*ID_BITS + 8;
	localparam int ITEMS_PER_PHASE = 140;
	localparam int LONG_HOLD = 120;
	// Index past the end of the register file; the write must be dropped
	localparam logic [7:0] REG_UNUSED = REG_OWN_NODE + 8'd5;

	typedef struct packed {
		logic [1:0] min_hops;
		logic [2:0] detour_hops;
		logic       bad_node;
	} hop_result_t;

	typedef struct {
		logic [ID_BITS-1:0] via;
		logic [ID_BITS-1:0] target;
		bit                 typed;
		hop_result_t        res;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [7:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [ID_BITS-1:0] via_node = '0;
	logic [ID_BITS-1:0] target_node = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] min_hops;
	logic [2:0] detour_hops;
	logic bad_node;

	// Local copy of the topology registers
	logic [P_BITS-1:0]   cur_p = P_RESET;
	logic [A_BITS-1:0]   cur_a = A_RESET;
	logic [H_BITS-1:0]   cur_h = H_RESET;
	logic [OWN_BITS-1:0] cur_own = OWN_RESET;

	hop_result_t pending_hops[$];
	int errors = 0;
	int checked = 0;
	int cycles = 0;
	bit quiet = 1'b0;
	bit long_hold_req = 1'b0;

	dragonfly_path_length_calc #(.NODE_ID_BITS(ID_BITS)) uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	function automatic bit link_on(int unsigned g, int unsigned r, int unsigned t);
		int unsigned lo;
		lo = r * cur_h + ((t > g) ? 1 : 0);
		return t >= lo && t < lo + cur_h;
	endfunction

	function automatic int unsigned seg_hops(int unsigned sg, int unsigned sr,
			int unsigned dg, int unsigned dr, bit full);
		int unsigned n;
		if (sg == dg)
			return (sr != dr) ? 1 : 0;
		n = 1;
		if (!link_on(sg, sr, dg))
			n++;
		if (full && !link_on(dg, dr, sg))
			n++;
		return n;
	endfunction

	// Hop counts from own_node via an intermediate node to a target
	function automatic hop_result_t path_hops(logic [ID_BITS-1:0] via, logic [ID_BITS-1:0] tgt);
		int unsigned p, a, lim;
		int unsigned g[3], r[3];
		logic [ID_BITS-1:0] id[3];
		hop_result_t res;
		p = (cur_p != 0) ? cur_p : 1;
		a = (cur_a != 0) ? cur_a : 1;
		lim = a * cur_h;
		id[0] = cur_own;
		id[1] = via;
		id[2] = tgt;
		res.bad_node = 1'b0;
		for (int i = 0; i < 3; i++) begin
			g[i] = id[i] / (a * p);
			r[i] = (id[i] / p) % a;
			if (g[i] > lim)
				res.bad_node = 1'b1;
		end
		res.min_hops = 2'(seg_hops(g[0], r[0], g[2], r[2], 1'b1));
		res.detour_hops = 3'(seg_hops(g[0], r[0], g[1], r[1], 1'b0)
			+ seg_hops(g[1], r[1], g[2], r[2], 1'b1));
		return res;
	endfunction

	// Mostly ids inside the configured topology, some anywhere
	function automatic logic [ID_BITS-1:0] pick_id();
		int unsigned p, a, span;
		p = (cur_p != 0) ? cur_p : 1;
		a = (cur_a != 0) ? cur_a : 1;
		span = a * p * (a * cur_h + 1);
		if (span > 65536)
			span = 65536;
		if ($urandom_range(0, 3) == 0)
			return ID_BITS'($urandom);
		return ID_BITS'($urandom_range(0, span - 1));
	endfunction

	task automatic write_reg(logic [7:0] idx, logic [CFG_DATA_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_NODES_PER_ROUTER:  cur_p = val[P_BITS-1:0];
			REG_ROUTERS_PER_GROUP: cur_a = val[A_BITS-1:0];
			REG_GLOBAL_PORTS:      cur_h = val[H_BITS-1:0];
			REG_OWN_NODE:          cur_own = val[OWN_BITS-1:0];
			default: ;
		endcase
	endtask

	// Offer one request, hold it until taken, then queue the expected hops
	task automatic send_request(logic [ID_BITS-1:0] via, logic [ID_BITS-1:0] tgt,
			bit typed, hop_result_t res);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		via_node <= via;
		target_node <= tgt;
		do
			@(posedge clk);
		while (!in_ready);
		pending_hops.insert(pending_hops.size(), typed ? res : path_hops(via, tgt));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_hops.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: random stalls, and one long hold on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		hop_result_t want;
		if (arst_n && out_valid && out_ready) begin
			checked++;
			if (pending_hops.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result min=%0d detour=%0d bad=%0d",
						min_hops, detour_hops, bad_node);
			end else begin
				want = pending_hops.pop_front();
				if (want.min_hops !== min_hops || want.detour_hops !== detour_hops
						|| want.bad_node !== bad_node) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: expected min=%0d detour=%0d bad=%0d,",
							" got min=%0d detour=%0d bad=%0d"},
							want.min_hops, want.detour_hops, want.bad_node,
							min_hops, detour_hops, bad_node);
				end
			end
		end
	end

	initial begin
		vector_t vecs[$];
		hop_result_t nores;
		logic [ID_BITS-1:0] v, t;
		int unsigned settings[6][3];
		int directed;

		nores = '0;
		// Directed table at the reset topology p=4 a=8 h=4 own=0
		vecs.insert(vecs.size(), '{16'h0000, 16'h0000, 1, '{2'd0, 3'd0, 1'b0}});
		vecs.insert(vecs.size(), '{16'h0000, 16'h0004, 1, '{2'd1, 3'd1, 1'b0}});
		vecs.insert(vecs.size(), '{16'h0000, 16'hFFFF, 1, '{2'd3, 3'd3, 1'b1}});
		vecs.insert(vecs.size(), '{16'hFFFF, 16'h0000, 0, nores});
		vecs.insert(vecs.size(), '{16'hFFFF, 16'hFFFF, 0, nores});
		vecs.insert(vecs.size(), '{16'hAAAA, 16'h5555, 0, nores});
		vecs.insert(vecs.size(), '{16'h5555, 16'hAAAA, 0, nores});
		vecs.insert(vecs.size(), '{16'd32, 16'd64, 0, nores});
		vecs.insert(vecs.size(), '{16'd36, 16'd0, 0, nores});
		vecs.insert(vecs.size(), '{16'd1056, 16'd1055, 0, nores});
		vecs.insert(vecs.size(), '{16'd1056, 16'd1057, 0, nores});
		vecs.insert(vecs.size(), '{16'd28, 16'd160, 0, nores});
		vecs.insert(vecs.size(), '{16'd3, 16'd31, 0, nores});
		vecs.insert(vecs.size(), '{16'd544, 16'd900, 0, nores});
		directed = vecs.size();

		// p, a, h per phase; the extremes, zero registers, and all-ones field values
		settings = '{'{1, 1, 1}, '{64, 128, 64}, '{0, 0, 0}, '{127, 255, 127},
			'{3, 5, 2}, '{4, 8, 4}};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (vecs[i])
			send_request(vecs[i].via, vecs[i].target, vecs[i].typed, vecs[i].res);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			write_reg(REG_NODES_PER_ROUTER, CFG_DATA_BITS'(settings[ph][0]));
			write_reg(REG_ROUTERS_PER_GROUP, CFG_DATA_BITS'(settings[ph][1]));
			write_reg(REG_GLOBAL_PORTS, CFG_DATA_BITS'(settings[ph][2]));
			if (ph == 3)
				write_reg(REG_OWN_NODE, 16'hFFFF);
			else if (ph == 5)
				write_reg(REG_OWN_NODE, 16'h0000);
			else
				write_reg(REG_OWN_NODE, pick_id());
			write_reg(REG_UNUSED, 16'h0001);
			if (ph == 1)
				long_hold_req = 1'b1;
			if (ph == 5)
				quiet = 1'b1;
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				v = pick_id();
				// Now and then pick the target close to the via node, often in its group
				t = ($urandom_range(0, 4) == 0) ? v ^ ID_BITS'($urandom_range(0, 7)) : pick_id();
				send_request(v, t, 1'b0, nores);
			end
		end

		wait_idle();
		$display("covered %0d directed and %0d random requests over 6 topology settings",
			directed, 6 * ITEMS_PER_PHASE);
		$display("%0d results checked, %0d mismatches", checked, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: files.f
sv/dfpl_pkg.sv
sv/dfpl_div.sv
sv/dfpl_hops.sv
sv/dragonfly_path_length_calc.sv
bench/dragonfly_path_length_calc_tb.sv
